/* hdl/wplb_pkg.sv */
package wplb_pkg;

  // pool size and derived widths
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_IN_W = 4;
  localparam int CMP_W     = ((SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W) + 1;
  localparam int CNT_W     = 16;

  // radix-4 minimum tree, reduced in place level by level
  localparam int RADIX  = 4;
  localparam int RED_N  = (NUM_SLOTS + RADIX - 1) / RADIX;
  localparam int LEVELS = ($clog2(NUM_SLOTS) + 1) / 2;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // defaults selected by a zero limit
  localparam logic [CNT_W-1:0] FIXED_DEFAULT = 16'd10;
  localparam logic [CNT_W-1:0] GROW_DEFAULT  = 16'd1000;
  localparam logic [CNT_W-1:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [CNT_W-1:0] LIMIT_RESET   = 16'd100;

  // operation codes on the op port
  localparam logic [1:0] OP_ASSIGN  = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // configuration register indexes
  localparam logic CFG_POOL_MODE = 1'b0;
  localparam logic CFG_LIMIT     = 1'b1;

  // pool modes
  localparam logic MODE_FIXED = 1'b0;
  localparam logic MODE_GROW  = 1'b1;

  typedef enum logic [1:0] {
    KIND_ASSIGN,
    KIND_RELEASE,
    KIND_CLEAR,
    KIND_BAD
  } kind_t;

  typedef enum logic [2:0] {
    ST_ASSIGNED = 3'd0,
    ST_RELEASED = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  // classified command word from the front to the back
  typedef struct packed {
    kind_t                kind;
    logic [SLOT_IN_W-1:0] slot;
    logic                 slot_ok;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [SLOT_IN_W-1:0] slot;
    status_t              status;
    logic [CNT_W-1:0]     count;
  } res_t;

endpackage

/* hdl/worker_pool_load_balancer_top.sv */
// an assign runs through the load, reduce and apply states of the radix-4 minimum
// search; release, clear and unknown words go straight to apply
// the single sequencer takes no new word until the last one has been applied, and it
// runs each word through the slot table; queues of two on each side
// reset: synchronous, clears both queues, all counts, active bits and the pool lock,
// and returns the registers to grow mode with a limit of 100
module worker_pool_load_balancer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    op,
  input  logic [wplb_pkg::SLOT_IN_W-1:0] slot_in,
  output logic                          empty,
  input  logic                          pop,
  output logic [wplb_pkg::SLOT_IN_W-1:0] slot_out,
  output logic [2:0]                    status,
  output logic [wplb_pkg::CNT_W-1:0]     count_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [wplb_pkg::CNT_W-1:0]     cfg_data
);
  import wplb_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_full;
  res_t res;

  // configuration is taken at any time, locked inside once the pool is set up
  assign cfg_ready = 1'b1;

  // front: accept and classify
  wplb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .slot_in   (slot_in),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back: pool table and search
  wplb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_valid (res_valid),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result queue
  wplb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_full  (res_full),
    .empty     (empty),
    .pop       (pop),
    .slot_out  (slot_out),
    .status    (status),
    .count_out (count_out)
  );

endmodule

/* hdl/wplb_front.sv */
module wplb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    op,
  input  logic [wplb_pkg::SLOT_IN_W-1:0] slot_in,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output wplb_pkg::cmd_t                cmd
);
  import wplb_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       wr;
  logic       rd;
  cmd_t       cmd_in;

  // classify the incoming word
  always_comb begin
    cmd_in.slot    = slot_in;
    cmd_in.slot_ok = CMP_W'(slot_in) < CMP_W'(NUM_SLOTS);
    case (op)
      OP_ASSIGN:  cmd_in.kind = KIND_ASSIGN;
      OP_RELEASE: cmd_in.kind = KIND_RELEASE;
      OP_CLEAR:   cmd_in.kind = KIND_CLEAR;
      default:    cmd_in.kind = KIND_BAD;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign wr        = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign rd        = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  // two-entry command queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) q[wr_ptr] <= cmd_in;
  end

endmodule

/* hdl/wplb_back.sv */
module wplb_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  wplb_pkg::cmd_t            cmd,
  input  logic                      res_full,
  output logic                      res_valid,
  output wplb_pkg::res_t            res,
  input  logic                      cfg_valid,
  input  logic                      cfg_index,
  input  logic [wplb_pkg::CNT_W-1:0] cfg_data
);
  import wplb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_REDUCE,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  key;
    logic [SLOT_W-1:0] idx;
  } cand_t;

  state_t                state;
  cmd_t                  cur;
  logic [LVL_W-1:0]      lvl;
  logic [CNT_W-1:0]      slot_count [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  slot_active;
  logic                  pool_ready;
  logic                  pool_mode;
  logic [CNT_W-1:0]      pool_limit;
  cand_t                 cand      [NUM_SLOTS];
  cand_t                 cand_leaf [NUM_SLOTS];
  cand_t                 cand_red  [NUM_SLOTS];
  cand_t                 best;
  logic [CNT_W-1:0]      grow_cap;
  logic [CNT_W-1:0]      fixed_n;
  logic [NUM_SLOTS-1:0]  setup_mask;
  logic                  take;
  logic [SLOT_W-1:0]     rd_addr;
  logic [CNT_W-1:0]      cnt_rd;
  logic                  act_rd;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CNT_W-1:0]      cnt_dec;
  logic                  others;
  logic                  cnt_we;
  logic [CNT_W-1:0]      cnt_wd;
  logic                  act_we;
  logic                  act_wd;
  logic                  clr_all;

  // keep the lower entry unless the higher one is strictly better
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (b.valid && (!a.valid || (b.key < a.key))) r = b;
    return r;
  endfunction

  assign grow_cap = (pool_limit == '0) ? GROW_DEFAULT : pool_limit;
  assign fixed_n  = (pool_limit == '0) ? FIXED_DEFAULT : pool_limit;
  assign take     = (state == S_IDLE) && cmd_valid && !res_full;
  assign cmd_ready = take;

  // slots made active when the pool is set up
  always_comb begin
    setup_mask = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pool_mode == MODE_FIXED) setup_mask[i] = CNT_W'(i) < fixed_n;
    end
    if (pool_mode == MODE_GROW) setup_mask[0] = 1'b1;
  end

  // tree leaves: load in fixed mode, fit before free in grow mode
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cand_leaf[i].idx = SLOT_W'(i);
      if (pool_mode == MODE_FIXED) begin
        cand_leaf[i].valid = slot_active[i];
        cand_leaf[i].key   = slot_count[i];
      end else if (slot_active[i]) begin
        cand_leaf[i].valid = slot_count[i] < grow_cap;
        cand_leaf[i].key   = '0;
      end else begin
        cand_leaf[i].valid = 1'b1;
        cand_leaf[i].key   = CNT_W'(1);
      end
    end
  end

  // one radix-4 tree level, each node folds its children in index order
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cand_red[i] = '0;
      if (i < RED_N) begin
        for (int k = 0; k < RADIX; k++) begin
          if (RADIX * i + k < NUM_SLOTS) cand_red[i] = pick(cand_red[i], cand[RADIX * i + k]);
        end
      end
    end
  end

  assign best = cand[0];

  // single read port into the slot table
  assign rd_addr = (cur.kind == KIND_RELEASE) ? SLOT_W'(cur.slot) : best.idx;
  assign cnt_rd  = slot_count[rd_addr];
  assign act_rd  = slot_active[rd_addr];
  assign cnt_inc = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + CNT_W'(1);
  assign cnt_dec = (cnt_rd == '0) ? cnt_rd : cnt_rd - CNT_W'(1);
  assign others  = |(slot_active & ~(NUM_SLOTS'(1) << rd_addr));

  // outcome of the current command
  always_comb begin
    res.slot   = '0;
    res.status = ST_IGNORED;
    res.count  = '0;
    cnt_we     = 1'b0;
    cnt_wd     = '0;
    act_we     = 1'b0;
    act_wd     = 1'b0;
    clr_all    = 1'b0;
    case (cur.kind)
      KIND_ASSIGN: begin
        if (!best.valid) begin
          res.status = ST_FULL;
        end else if (act_rd) begin
          cnt_we     = 1'b1;
          cnt_wd     = cnt_inc;
          res.slot   = SLOT_IN_W'(best.idx);
          res.status = ST_ASSIGNED;
          res.count  = cnt_inc;
        end else begin
          cnt_we     = 1'b1;
          cnt_wd     = CNT_W'(1);
          act_we     = 1'b1;
          act_wd     = 1'b1;
          res.slot   = SLOT_IN_W'(best.idx);
          res.status = ST_ASSIGNED;
          res.count  = CNT_W'(1);
        end
      end
      KIND_RELEASE: begin
        res.slot = cur.slot;
        if (cur.slot_ok && act_rd) begin
          cnt_we = 1'b1;
          if (pool_mode == MODE_GROW && cnt_dec == '0 && others) begin
            cnt_wd     = '0;
            act_we     = 1'b1;
            act_wd     = 1'b0;
            res.status = ST_REMOVED;
          end else begin
            cnt_wd     = cnt_dec;
            res.status = ST_RELEASED;
            res.count  = cnt_dec;
          end
        end
      end
      KIND_CLEAR: begin
        clr_all    = 1'b1;
        res.status = ST_CLEARED;
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase
  end

  assign res_valid = (state == S_APPLY);

  // sequencer, pool table and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lvl         <= '0;
      pool_ready  <= 1'b0;
      pool_mode   <= MODE_GROW;
      pool_limit  <= LIMIT_RESET;
      slot_active <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_count[i] <= '0;
    end else begin
      if (cfg_valid && !pool_ready) begin
        case (cfg_index)
          CFG_POOL_MODE: pool_mode  <= cfg_data[0];
          CFG_LIMIT:     pool_limit <= cfg_data;
          default:       ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            cur <= cmd;
            if (!pool_ready) begin
              slot_active <= slot_active | setup_mask;
              pool_ready  <= 1'b1;
            end
            state <= (cmd.kind == KIND_ASSIGN) ? S_LOAD : S_APPLY;
          end
        end
        S_LOAD: begin
          cand  <= cand_leaf;
          lvl   <= '0;
          state <= S_REDUCE;
        end
        S_REDUCE: begin
          cand <= cand_red;
          lvl  <= lvl + LVL_W'(1);
          if (lvl == LVL_W'(LEVELS - 1)) state <= S_APPLY;
        end
        S_APPLY: begin
          if (clr_all) begin
            for (int i = 0; i < NUM_SLOTS; i++) slot_count[i] <= '0;
          end
          if (cnt_we) slot_count[rd_addr] <= cnt_wd;
          if (act_we) slot_active[rd_addr] <= act_wd;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/wplb_outq.sv */
module wplb_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  input  wplb_pkg::res_t                res,
  output logic                          res_full,
  output logic                          empty,
  input  logic                          pop,
  output logic [wplb_pkg::SLOT_IN_W-1:0] slot_out,
  output logic [2:0]                    status,
  output logic [wplb_pkg::CNT_W-1:0]     count_out
);
  import wplb_pkg::*;

  res_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       wr;
  logic       rd;

  assign res_full  = (cnt == 2'd2);
  assign empty     = (cnt == 2'd0);
  assign wr        = res_valid && !res_full;
  assign rd        = pop && !empty;
  assign slot_out  = q[rd_ptr].slot;
  assign status    = q[rd_ptr].status;
  assign count_out = q[rd_ptr].count;

  // two-entry result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) q[wr_ptr] <= res;
  end

endmodule

/* hdl/wplb_checker.sv */
module wplb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          empty,
  input logic                          pop,
  input logic [wplb_pkg::SLOT_IN_W-1:0] slot_out,
  input logic [2:0]                    status,
  input logic [wplb_pkg::CNT_W-1:0]     count_out
);
  import wplb_pkg::*;

  // reset drains the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(slot_out) && $stable(status) && $stable(count_out)))
    else $error("waiting result changed");

  // pool full carries no slot and no count
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_FULL) |-> (slot_out == '0 && count_out == '0))
    else $error("pool full word not zeroed");

  // an assigned slot always holds at least one connection
  a_assign_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_ASSIGNED) |-> (count_out != '0))
    else $error("assign reported a zero count");

  // removal and clear leave a zero count
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == ST_REMOVED || status == ST_CLEARED)) |-> (count_out == '0))
    else $error("removal or clear reported a count");

endmodule

bind worker_pool_load_balancer_top wplb_checker u_wplb_checker (.*);
